>>> rtl/core/fwo_pkg.sv
// Shared types, constants and command codes of the factor weight optimizer.
package fwo_pkg;

  localparam int MAX_FACTORS = 16;
  localparam int IDX_W       = 4;
  localparam int N_W         = 5;
  localparam int MAX_SAMPLES = 4095;
  localparam int CNT_W       = 13;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 43;
  localparam int MAG_W       = 27;
  localparam int PROD_W      = 56;
  localparam int ROOT_W      = 28;
  localparam int STEP_W      = 5;
  localparam int ARITH_STEPS = 28;
  localparam int DIV_NW      = 36;
  localparam int DIV_DW      = 28;
  localparam int DIV_CW      = 6;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] MODE_EQUAL  = 2'd0;
  localparam logic [1:0] MODE_IC     = 2'd1;
  localparam logic [1:0] MODE_ICIR   = 2'd2;
  localparam logic [1:0] MODE_SINGLE = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_DATA = 2'd1;
  localparam logic [1:0] STS_TOO_FEW = 2'd2;

  localparam logic [1:0] REG_METHOD      = 2'd0;
  localparam logic [1:0] REG_NUM_FACTORS = 2'd1;
  localparam logic [1:0] REG_MIN_SAMPLES = 2'd2;
  localparam logic [1:0] REG_WEIGHT_CAP  = 2'd3;

  localparam logic [4:0] CMD_NONE        = 5'd0;
  localparam logic [4:0] CMD_CLEAR       = 5'd1;
  localparam logic [4:0] CMD_ADD         = 5'd2;
  localparam logic [4:0] CMD_RUN_INIT    = 5'd3;
  localparam logic [4:0] CMD_CHECK       = 5'd4;
  localparam logic [4:0] CMD_LOAD        = 5'd5;
  localparam logic [4:0] CMD_MEAN        = 5'd6;
  localparam logic [4:0] CMD_MUL_A       = 5'd7;
  localparam logic [4:0] CMD_MUL_B       = 5'd8;
  localparam logic [4:0] CMD_SQRT        = 5'd9;
  localparam logic [4:0] CMD_ICIR        = 5'd10;
  localparam logic [4:0] CMD_IR_ZERO     = 5'd11;
  localparam logic [4:0] CMD_TOT         = 5'd12;
  localparam logic [4:0] CMD_RAW         = 5'd13;
  localparam logic [4:0] CMD_WDIV        = 5'd14;
  localparam logic [4:0] CMD_EMIT        = 5'd15;
  localparam logic [4:0] CMD_EMIT_ERR    = 5'd16;
  localparam logic [4:0] CMD_EMIT_SINGLE = 5'd17;

  typedef struct packed {
    logic [1:0]  method;
    logic [4:0]  num_factors;
    logic [11:0] min_samples;
    logic [16:0] weight_cap;
  } cfg_t;

  typedef struct packed {
    logic [4:0]       code;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
    logic idx_last;
    logic single;
    logic zero_found;
    logic few_found;
    logic c_lt2;
    logic a_le_b;
    logic r_zero;
    logic prop_ok;
  } sts_t;

endpackage

>>> rtl/core/factor_weight_optimizer.sv
// Top level of the factor weight optimizer: register port, controller and datapath.
//
//  Channel  Direction  Carries
//  in_*     request    tuser: op; tdata: factor, ic_value
//  out_*    result     tuser: status, mode_used; tdata: factor_res .. negative_icir; tlast
//  cfg_*    registers  method, num_factors, min_samples, weight_cap at 0x0, 0x4, 0x8, 0xC
//
// Clear and add-sample requests are handled in the idle state. A run first checks every factor,
// then for each factor uses up to two divisions, two serial multiplies and a root, each
// started from its own issue state, all in one shared set of units. The weights need a total
// over the factors, a raw weight division a factor in the IC and ICIR modes, and a final
// weight division a factor. Reset is synchronous and clears the sums. A stalled result
// holds the run in place; once the last result is registered the next request can enter.
module factor_weight_optimizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] factor, [19:4] ic_value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [3:0] factor_res, [20:4] weight, [36:21] ic_mean,
                                  // [52:37] icir, [53] negative_icir, rest zero
  output logic [3:0]  out_tuser,  // [1:0] status, [3:2] mode_used
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  fwo_pkg::cfg_t cfg_r;
  fwo_pkg::cmd_t cmd;
  fwo_pkg::sts_t sts;
  logic          cfg_we;
  logic [1:0]    reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.method      <= 2'd0;
      cfg_r.num_factors <= 5'd1;
      cfg_r.min_samples <= 12'd0;
      cfg_r.weight_cap  <= 17'd0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        fwo_pkg::REG_METHOD:      cfg_r.method      <= cfg_pwdata[1:0];
        fwo_pkg::REG_NUM_FACTORS: cfg_r.num_factors <= cfg_pwdata[4:0];
        fwo_pkg::REG_MIN_SAMPLES: cfg_r.min_samples <= cfg_pwdata[11:0];
        fwo_pkg::REG_WEIGHT_CAP:  cfg_r.weight_cap  <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fwo_pkg::REG_METHOD:      cfg_prdata = 32'(cfg_r.method);
      fwo_pkg::REG_NUM_FACTORS: cfg_prdata = 32'(cfg_r.num_factors);
      fwo_pkg::REG_MIN_SAMPLES: cfg_prdata = 32'(cfg_r.min_samples);
      fwo_pkg::REG_WEIGHT_CAP:  cfg_prdata = 32'(cfg_r.weight_cap);
      default:                  cfg_prdata = '0;
    endcase
  end

  fwo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fwo_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cmd         (cmd),
    .in_factor   (in_tdata[3:0]),
    .in_ic_value (in_tdata[19:4]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .sts         (sts)
  );

endmodule

>>> rtl/core/fwo_div.sv
// Restoring divider that resolves one quotient bit per cycle.
module fwo_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fwo_pkg::DIV_NW-1:0] dividend,
  input  logic [fwo_pkg::DIV_DW-1:0] divisor,
  output logic                      done,
  output logic [fwo_pkg::DIV_NW-1:0] quot
);

  logic                       busy_r, busy_nxt;
  logic [fwo_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [fwo_pkg::DIV_NW-1:0] num_r, num_nxt;
  logic [fwo_pkg::DIV_DW-1:0] rem_r, rem_nxt;
  logic [fwo_pkg::DIV_DW-1:0] den_r, den_nxt;
  logic [fwo_pkg::DIV_DW:0]   rem_ext, rem_sub;
  logic                       ge;

  always_comb begin
    rem_ext = {rem_r, num_r[fwo_pkg::DIV_NW-1]};
    ge      = rem_ext >= {1'b0, den_r};
    rem_sub = rem_ext - {1'b0, den_r};
    done    = busy_r && (cnt_r == '0);
    quot    = {num_r[fwo_pkg::DIV_NW-2:0], ge};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fwo_pkg::DIV_CW'(fwo_pkg::DIV_NW - 1);
      num_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = quot;
      rem_nxt = ge ? rem_sub[fwo_pkg::DIV_DW-1:0] : rem_ext[fwo_pkg::DIV_DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

endmodule

>>> rtl/core/fwo_dp.sv
// Datapath: per-factor accumulators, serial multiplier and root, divider and result register.
module fwo_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fwo_pkg::cfg_t        cfg,
  input  fwo_pkg::cmd_t        cmd,
  input  logic [3:0]           in_factor,
  input  logic signed [15:0]   in_ic_value,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [55:0]          out_tdata,
  output logic [3:0]           out_tuser,
  output logic                 out_tlast,
  output fwo_pkg::sts_t        sts
);

  localparam int NF = fwo_pkg::MAX_FACTORS;

  // Accumulator stores.
  logic [fwo_pkg::CNT_W-1:0]        count_r [NF];
  logic signed [fwo_pkg::SUM_W-1:0] sum_r   [NF];
  logic [fwo_pkg::SQ_W-1:0]         sq_r    [NF];

  // Per-run results.
  logic signed [15:0] means_r [NF];
  logic signed [15:0] irs_r   [NF];
  logic [16:0]        raw_r   [NF];

  logic [fwo_pkg::CNT_W-1:0]        c_r;
  logic signed [fwo_pkg::SUM_W-1:0] s_r;
  logic [fwo_pkg::SQ_W-1:0]         sqw_r;
  logic [fwo_pkg::MAG_W-1:0]        mag_r;
  logic [fwo_pkg::PROD_W-1:0]       a_r, b_r;
  logic [fwo_pkg::ROOT_W-1:0]       r_r;
  logic [19:0]                      tot_r;
  logic [20:0]                      s2_r;
  logic [16:0]                      w_r;
  logic                             zero_found_r, few_found_r;
  logic [fwo_pkg::IDX_W-1:0]        zero_idx_r, few_idx_r;
  logic [4:0]                       pend_r;

  // Serial multiplier and root share one step counter.
  logic                        mul_busy_r, sqrt_busy_r;
  logic [fwo_pkg::STEP_W-1:0]  step_r;
  logic [fwo_pkg::PROD_W-1:0]  acc_r, ash_r, acc_nxt;
  logic [fwo_pkg::ROOT_W-1:0]  bsh_r;
  logic [fwo_pkg::PROD_W-1:0]  x_r;
  logic [29:0]                 rem_r;
  logic [fwo_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [31:0]                 rt_ext, rt_trial;
  logic                        rt_ge;
  logic                        mul_done, sqrt_done;

  logic                        out_valid_r;
  logic [3:0]                  o_factor_r;
  logic [16:0]                 o_weight_r;
  logic [15:0]                 o_mean_r, o_icir_r;
  logic                        o_neg_r, o_last_r;
  logic [1:0]                  o_status_r, o_mode_r;

  logic [fwo_pkg::IDX_W-1:0]        rd_idx;
  logic [fwo_pkg::CNT_W-1:0]        cnt_rd;
  logic signed [fwo_pkg::SUM_W-1:0] sum_rd;
  logic [fwo_pkg::SUM_W-1:0]        sum_abs;
  logic [31:0]                      sq_inc;
  logic [fwo_pkg::N_W-1:0]          n_eff;
  logic [1:0]                       mode;
  logic [15:0]                      val;
  logic signed [15:0]               mean_sel, ir_sel;
  logic                             div_start, div_done;
  logic [fwo_pkg::DIV_NW-1:0]       div_n, div_q;
  logic [fwo_pkg::DIV_DW-1:0]       div_d;
  logic [fwo_pkg::SUM_W-1:0]        mean_num;
  logic [16:0]                      m17, raw_w;
  logic signed [15:0]               mean_res, icir_res;
  logic                             cap_on, out_free;

  always_comb begin
    rd_idx  = (cmd.code == fwo_pkg::CMD_ADD) ? in_factor : cmd.idx;
    cnt_rd  = count_r[rd_idx];
    sum_rd  = sum_r[rd_idx];
    sum_abs = sum_rd[fwo_pkg::SUM_W-1] ? fwo_pkg::SUM_W'(-sum_rd) : fwo_pkg::SUM_W'(sum_rd);
    sq_inc  = 32'(in_ic_value * in_ic_value);

    if (cfg.num_factors == '0) begin
      n_eff = fwo_pkg::N_W'(1);
    end else if (cfg.num_factors > fwo_pkg::N_W'(NF)) begin
      n_eff = fwo_pkg::N_W'(NF);
    end else begin
      n_eff = cfg.num_factors;
    end
    mode = (cfg.method == fwo_pkg::MODE_IC || cfg.method == fwo_pkg::MODE_ICIR) ?
           cfg.method : fwo_pkg::MODE_EQUAL;

    mean_sel = means_r[cmd.idx];
    ir_sel   = irs_r[cmd.idx];
    if (mode == fwo_pkg::MODE_IC) begin
      val = mean_sel[15] ? 16'(-mean_sel) : 16'(mean_sel);
    end else if (mode == fwo_pkg::MODE_ICIR) begin
      val = ir_sel[15] ? 16'd0 : 16'(ir_sel);
    end else begin
      val = 16'd0;
    end

    // Operand selection for the shared divider.
    mean_num  = fwo_pkg::SUM_W'(mag_r) + fwo_pkg::SUM_W'(c_r >> 1);
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (cmd.code)
      fwo_pkg::CMD_MEAN: begin
        div_start = 1'b1;
        div_n     = fwo_pkg::DIV_NW'(mean_num);
        div_d     = fwo_pkg::DIV_DW'(c_r);
      end
      fwo_pkg::CMD_ICIR: begin
        div_start = 1'b1;
        div_n     = fwo_pkg::DIV_NW'({mag_r, 8'd0});
        div_d     = r_r;
      end
      fwo_pkg::CMD_RAW: begin
        div_start = 1'b1;
        div_n     = fwo_pkg::DIV_NW'({val, 16'd0});
        div_d     = fwo_pkg::DIV_DW'(tot_r);
      end
      fwo_pkg::CMD_WDIV: begin
        div_start = 1'b1;
        if (s2_r == '0) begin
          div_n = fwo_pkg::DIV_NW'(fwo_pkg::ONE_Q16);
          div_d = fwo_pkg::DIV_DW'(n_eff);
        end else begin
          div_n = fwo_pkg::DIV_NW'({raw_r[cmd.idx], 16'd0});
          div_d = fwo_pkg::DIV_DW'(s2_r);
        end
      end
      default: ;
    endcase

    // Saturation of division results.
    m17 = (div_q > fwo_pkg::DIV_NW'(32768)) ? 17'd32768 : div_q[16:0];
    if (s_r < 0) begin
      mean_res = 16'(-m17);
      icir_res = (div_q >= fwo_pkg::DIV_NW'(32768)) ? 16'sh8000 : 16'(-div_q[15:0]);
    end else begin
      mean_res = (m17 > 17'd32767) ? 16'sh7FFF : 16'(m17);
      icir_res = (div_q >= fwo_pkg::DIV_NW'(32767)) ? 16'sh7FFF : 16'(div_q[15:0]);
    end
    cap_on = (cfg.weight_cap != '0) && (cfg.weight_cap < fwo_pkg::ONE_Q16);
    raw_w  = (cap_on && div_q[16:0] > cfg.weight_cap) ? cfg.weight_cap : div_q[16:0];

    acc_nxt   = acc_r + (bsh_r[0] ? ash_r : '0);
    rt_ext    = {rem_r, x_r[fwo_pkg::PROD_W-1 -: 2]};
    rt_trial  = {2'b00, root_r, 2'b01};
    rt_ge     = rt_ext >= rt_trial;
    root_nxt  = {root_r[fwo_pkg::ROOT_W-2:0], rt_ge};
    mul_done  = mul_busy_r && (step_r == '0);
    sqrt_done = sqrt_busy_r && (step_r == '0);
    out_free  = !out_valid_r || out_tready;

    sts.done       = div_done || mul_done || sqrt_done;
    sts.out_free   = out_free;
    sts.idx_last   = {1'b0, cmd.idx} == (n_eff - 1'b1);
    sts.single     = n_eff == fwo_pkg::N_W'(1);
    sts.zero_found = zero_found_r;
    sts.few_found  = few_found_r;
    sts.c_lt2      = c_r < fwo_pkg::CNT_W'(2);
    sts.a_le_b     = a_r <= b_r;
    sts.r_zero     = r_r == '0;
    sts.prop_ok    = (mode != fwo_pkg::MODE_EQUAL) && (tot_r != '0);
  end

  fwo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q)
  );

  // Accumulator stores, cleared by reset and by a clear request.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.code == fwo_pkg::CMD_CLEAR) begin
      for (int i = 0; i < NF; i++) begin
        count_r[i] <= '0;
        sum_r[i]   <= '0;
        sq_r[i]    <= '0;
      end
    end else if (cmd.code == fwo_pkg::CMD_ADD &&
                 cnt_rd < fwo_pkg::CNT_W'(fwo_pkg::MAX_SAMPLES)) begin
      count_r[rd_idx] <= cnt_rd + 1'b1;
      sum_r[rd_idx]   <= sum_rd + fwo_pkg::SUM_W'(in_ic_value);
      sq_r[rd_idx]    <= sq_r[rd_idx] + fwo_pkg::SQ_W'(sq_inc);
    end
  end

  // Control flags of a run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_found_r <= 1'b0;
      few_found_r  <= 1'b0;
      mul_busy_r   <= 1'b0;
      sqrt_busy_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.code == fwo_pkg::CMD_RUN_INIT) begin
        zero_found_r <= 1'b0;
        few_found_r  <= 1'b0;
      end else if (cmd.code == fwo_pkg::CMD_CHECK) begin
        if (cnt_rd == '0 && !zero_found_r) begin
          zero_found_r <= 1'b1;
        end
        if (cnt_rd < {1'b0, cfg.min_samples} && !few_found_r) begin
          few_found_r <= 1'b1;
        end
      end
      if (cmd.code == fwo_pkg::CMD_MUL_A || cmd.code == fwo_pkg::CMD_MUL_B) begin
        mul_busy_r <= 1'b1;
      end else if (mul_done) begin
        mul_busy_r <= 1'b0;
      end
      if (cmd.code == fwo_pkg::CMD_SQRT) begin
        sqrt_busy_r <= 1'b1;
      end else if (sqrt_done) begin
        sqrt_busy_r <= 1'b0;
      end
      if (cmd.code == fwo_pkg::CMD_EMIT || cmd.code == fwo_pkg::CMD_EMIT_ERR ||
          cmd.code == fwo_pkg::CMD_EMIT_SINGLE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and result stores.
  always_ff @(posedge clk) begin
    if (cmd.code == fwo_pkg::CMD_CHECK) begin
      if (cnt_rd == '0 && !zero_found_r) begin
        zero_idx_r <= cmd.idx;
      end
      if (cnt_rd < {1'b0, cfg.min_samples} && !few_found_r) begin
        few_idx_r <= cmd.idx;
      end
    end
    if (cmd.code == fwo_pkg::CMD_RUN_INIT) begin
      tot_r <= '0;
      s2_r  <= '0;
    end
    if (cmd.code == fwo_pkg::CMD_LOAD) begin
      c_r   <= cnt_rd;
      s_r   <= sum_rd;
      sqw_r <= sq_r[rd_idx];
      mag_r <= sum_abs[fwo_pkg::MAG_W-1:0];
    end
    if (cmd.code == fwo_pkg::CMD_TOT) begin
      tot_r <= tot_r + 20'(val);
    end
    if (cmd.code == fwo_pkg::CMD_IR_ZERO) begin
      irs_r[cmd.idx] <= '0;
    end
    if (div_start || cmd.code == fwo_pkg::CMD_MUL_A || cmd.code == fwo_pkg::CMD_MUL_B) begin
      pend_r <= cmd.code;
    end

    // Serial multiplier: one bit of the second operand a cycle.
    if (cmd.code == fwo_pkg::CMD_MUL_A) begin
      acc_r  <= '0;
      ash_r  <= fwo_pkg::PROD_W'(sqw_r);
      bsh_r  <= fwo_pkg::ROOT_W'(c_r);
      step_r <= fwo_pkg::STEP_W'(fwo_pkg::ARITH_STEPS - 1);
    end else if (cmd.code == fwo_pkg::CMD_MUL_B) begin
      acc_r  <= '0;
      ash_r  <= fwo_pkg::PROD_W'(mag_r);
      bsh_r  <= fwo_pkg::ROOT_W'(mag_r);
      step_r <= fwo_pkg::STEP_W'(fwo_pkg::ARITH_STEPS - 1);
    end else if (cmd.code == fwo_pkg::CMD_SQRT) begin
      x_r    <= a_r - b_r;
      rem_r  <= '0;
      root_r <= '0;
      step_r <= fwo_pkg::STEP_W'(fwo_pkg::ARITH_STEPS - 1);
    end else if (mul_busy_r) begin
      acc_r  <= acc_nxt;
      ash_r  <= {ash_r[fwo_pkg::PROD_W-2:0], 1'b0};
      bsh_r  <= bsh_r >> 1;
      step_r <= step_r - 1'b1;
      if (mul_done) begin
        if (pend_r == fwo_pkg::CMD_MUL_A) begin
          a_r <= acc_nxt;
        end else begin
          b_r <= acc_nxt;
        end
      end
    end else if (sqrt_busy_r) begin
      // Integer square root, two radicand bits a cycle.
      x_r    <= {x_r[fwo_pkg::PROD_W-3:0], 2'b00};
      rem_r  <= rt_ge ? 30'(rt_ext - rt_trial) : 30'(rt_ext);
      root_r <= root_nxt;
      step_r <= step_r - 1'b1;
      if (sqrt_done) begin
        r_r <= root_nxt;
      end
    end

    if (div_done) begin
      case (pend_r)
        fwo_pkg::CMD_MEAN: means_r[cmd.idx] <= mean_res;
        fwo_pkg::CMD_ICIR: irs_r[cmd.idx]   <= icir_res;
        fwo_pkg::CMD_RAW: begin
          raw_r[cmd.idx] <= raw_w;
          s2_r           <= s2_r + 21'(raw_w);
        end
        default: w_r <= div_q[16:0];
      endcase
    end

    case (cmd.code)
      fwo_pkg::CMD_EMIT: begin
        o_factor_r <= cmd.idx;
        o_weight_r <= w_r;
        o_mean_r   <= mean_sel;
        o_icir_r   <= ir_sel;
        o_neg_r    <= (mode == fwo_pkg::MODE_ICIR) && ir_sel[15];
        o_status_r <= fwo_pkg::STS_OK;
        o_mode_r   <= mode;
        o_last_r   <= sts.idx_last;
      end
      fwo_pkg::CMD_EMIT_ERR: begin
        o_factor_r <= zero_found_r ? zero_idx_r : few_idx_r;
        o_weight_r <= '0;
        o_mean_r   <= '0;
        o_icir_r   <= '0;
        o_neg_r    <= 1'b0;
        o_status_r <= zero_found_r ? fwo_pkg::STS_NO_DATA : fwo_pkg::STS_TOO_FEW;
        o_mode_r   <= fwo_pkg::MODE_EQUAL;
        o_last_r   <= 1'b1;
      end
      fwo_pkg::CMD_EMIT_SINGLE: begin
        o_factor_r <= '0;
        o_weight_r <= fwo_pkg::ONE_Q16;
        o_mean_r   <= means_r[0];
        o_icir_r   <= irs_r[0];
        o_neg_r    <= 1'b0;
        o_status_r <= fwo_pkg::STS_OK;
        o_mode_r   <= fwo_pkg::MODE_SINGLE;
        o_last_r   <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_neg_r, o_icir_r, o_mean_r, o_weight_r, o_factor_r};
  assign out_tuser  = {o_mode_r, o_status_r};
  assign out_tlast  = o_last_r;

endmodule

>>> rtl/core/fwo_ctrl.sv
// Controller: sequences requests and the per-factor steps of a run.
module fwo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [1:0]    in_op,
  output logic          in_tready,
  input  fwo_pkg::sts_t sts,
  output fwo_pkg::cmd_t cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHK     = 5'd1;
  localparam logic [4:0] S_CHK_END = 5'd2;
  localparam logic [4:0] S_ERR     = 5'd3;
  localparam logic [4:0] S_LOAD    = 5'd4;
  localparam logic [4:0] S_MEAN    = 5'd5;
  localparam logic [4:0] S_MULA    = 5'd6;
  localparam logic [4:0] S_MULB    = 5'd7;
  localparam logic [4:0] S_CMPAB   = 5'd8;
  localparam logic [4:0] S_SQRT    = 5'd9;
  localparam logic [4:0] S_RZ      = 5'd10;
  localparam logic [4:0] S_ICIR    = 5'd11;
  localparam logic [4:0] S_IRZERO  = 5'd12;
  localparam logic [4:0] S_NEXT    = 5'd13;
  localparam logic [4:0] S_SINGLE  = 5'd14;
  localparam logic [4:0] S_TOT     = 5'd15;
  localparam logic [4:0] S_TOT_END = 5'd16;
  localparam logic [4:0] S_RAW     = 5'd17;
  localparam logic [4:0] S_RAW_NX  = 5'd18;
  localparam logic [4:0] S_WDIV    = 5'd19;
  localparam logic [4:0] S_EMIT    = 5'd20;
  localparam logic [4:0] S_WAIT    = 5'd21;

  logic [4:0]                state_r, state_nxt, ret_r, ret_nxt;
  logic [fwo_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [4:0]                code;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    idx_nxt   = idx_r;
    code      = fwo_pkg::CMD_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (in_op)
            fwo_pkg::OP_CLEAR: code = fwo_pkg::CMD_CLEAR;
            fwo_pkg::OP_ADD:   code = fwo_pkg::CMD_ADD;
            fwo_pkg::OP_RUN: begin
              code      = fwo_pkg::CMD_RUN_INIT;
              idx_nxt   = '0;
              state_nxt = S_CHK;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        code = fwo_pkg::CMD_CHECK;
        if (sts.idx_last) begin
          state_nxt = S_CHK_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CHK_END: begin
        idx_nxt   = '0;
        state_nxt = (sts.zero_found || sts.few_found) ? S_ERR : S_LOAD;
      end
      S_ERR: begin
        if (sts.out_free) begin
          code      = fwo_pkg::CMD_EMIT_ERR;
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        code      = fwo_pkg::CMD_LOAD;
        state_nxt = S_MEAN;
      end
      S_MEAN: begin
        code      = fwo_pkg::CMD_MEAN;
        ret_nxt   = S_MULA;
        state_nxt = S_WAIT;
      end
      S_MULA: begin
        if (sts.c_lt2) begin
          state_nxt = S_IRZERO;
        end else begin
          code      = fwo_pkg::CMD_MUL_A;
          ret_nxt   = S_MULB;
          state_nxt = S_WAIT;
        end
      end
      S_MULB: begin
        code      = fwo_pkg::CMD_MUL_B;
        ret_nxt   = S_CMPAB;
        state_nxt = S_WAIT;
      end
      S_CMPAB: state_nxt = sts.a_le_b ? S_IRZERO : S_SQRT;
      S_SQRT: begin
        code      = fwo_pkg::CMD_SQRT;
        ret_nxt   = S_RZ;
        state_nxt = S_WAIT;
      end
      S_RZ: state_nxt = sts.r_zero ? S_IRZERO : S_ICIR;
      S_ICIR: begin
        code      = fwo_pkg::CMD_ICIR;
        ret_nxt   = S_NEXT;
        state_nxt = S_WAIT;
      end
      S_IRZERO: begin
        code      = fwo_pkg::CMD_IR_ZERO;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (sts.idx_last) begin
          idx_nxt   = '0;
          state_nxt = sts.single ? S_SINGLE : S_TOT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_SINGLE: begin
        if (sts.out_free) begin
          code      = fwo_pkg::CMD_EMIT_SINGLE;
          state_nxt = S_IDLE;
        end
      end
      S_TOT: begin
        code = fwo_pkg::CMD_TOT;
        if (sts.idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_TOT_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TOT_END: state_nxt = sts.prop_ok ? S_RAW : S_WDIV;
      S_RAW: begin
        code      = fwo_pkg::CMD_RAW;
        ret_nxt   = S_RAW_NX;
        state_nxt = S_WAIT;
      end
      S_RAW_NX: begin
        if (sts.idx_last) begin
          idx_nxt   = '0;
          state_nxt = S_WDIV;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RAW;
        end
      end
      S_WDIV: begin
        code      = fwo_pkg::CMD_WDIV;
        ret_nxt   = S_EMIT;
        state_nxt = S_WAIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          code = fwo_pkg::CMD_EMIT;
          if (sts.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_WDIV;
          end
        end
      end
      S_WAIT: begin
        if (sts.done) begin
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign cmd.code = code;
  assign cmd.idx  = idx_r;

endmodule
